FILE: rtl/sdsa_pkg.sv
// Shared types and constants for the step/direction DC servo axis.
// Used by the saturating step, the axis core and the top level.
`default_nettype none

package sdsa_pkg;

	localparam int POS_WIDTH = 32;
	localparam int DEADBAND_W = 16;
	localparam int FIELD_W = 32;
	localparam int ENC_W = 2;

	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd30;

	// Direction of a one-count move of a counter.
	typedef enum logic [1:0] {
		STEP_HOLD = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// Quadrature transitions, indexed by previous AB and then by current AB.
	// A double change of both lines counts as no move.
	localparam step_t ENC_DELTA [4][4] = '{
		'{STEP_HOLD, STEP_UP,   STEP_DOWN, STEP_HOLD},
		'{STEP_DOWN, STEP_HOLD, STEP_HOLD, STEP_UP  },
		'{STEP_UP,   STEP_HOLD, STEP_HOLD, STEP_DOWN},
		'{STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_HOLD}
	};

	typedef struct packed {
		logic enc_a;
		logic enc_b;
		logic step_level;
		logic dir_level;
	} in_item_t;

	typedef struct packed {
		logic                      drive_forward;
		logic                      drive_reverse;
		logic                      at_target;
		logic signed [FIELD_W-1:0] position_now;
		logic signed [FIELD_W-1:0] target_now;
	} res_item_t;

	typedef logic [DEADBAND_W-1:0] deadband_t;

endpackage

`default_nettype wire

FILE: rtl/sdsa_chan_if.sv
// Valid/ready channel carrying one beat of a generic payload.
// Payload types come from sdsa_pkg at the point of instantiation.
`default_nettype none

interface sdsa_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sdsa_sat_step.sv
// Saturating one-count move of a signed counter of width W.
// Depends on sdsa_pkg for the step code.
`default_nettype none

module sdsa_sat_step #(
	parameter int W = sdsa_pkg::POS_WIDTH
) (
	input  wire logic signed [W-1:0] value,
	input  wire sdsa_pkg::step_t     step,
	output logic signed [W-1:0]      result
);

	localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

	always_comb begin
		result = value;
		case (step)
			sdsa_pkg::STEP_UP: begin
				if (value != MAX_VAL) result = value + W'(1);
			end
			sdsa_pkg::STEP_DOWN: begin
				if (value != MIN_VAL) result = value - W'(1);
			end
			default: result = value;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/sdsa_axis_core.sv
// Axis state and update: encoder count, step/dir target, bang-bang drive.
// Depends on sdsa_pkg and sdsa_sat_step.
`default_nettype none

module sdsa_axis_core #(
	parameter int POS_WIDTH = sdsa_pkg::POS_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire sdsa_pkg::in_item_t  item,
	input  wire sdsa_pkg::deadband_t deadband,
	output sdsa_pkg::res_item_t      result
);

	localparam int W = POS_WIDTH;
	localparam int CW = (W + 1 > sdsa_pkg::DEADBAND_W) ? W + 1 : sdsa_pkg::DEADBAND_W;

	logic [sdsa_pkg::ENC_W-1:0] prev_enc_q;
	logic                       prev_step_q;
	logic signed [W-1:0]        position_q;
	logic signed [W-1:0]        target_q;
	logic                       reached_q;

	logic [sdsa_pkg::ENC_W-1:0] now_enc;
	sdsa_pkg::step_t            pos_step;
	sdsa_pkg::step_t            tgt_step;
	logic signed [W-1:0]        pos_next;
	logic signed [W-1:0]        tgt_next;
	logic signed [W:0]          diff;
	logic [W:0]                 mag;
	logic                       held;
	logic                       reached_next;

	assign now_enc  = {item.enc_a, item.enc_b};
	assign pos_step = sdsa_pkg::ENC_DELTA[prev_enc_q][now_enc];
	assign tgt_step = (item.step_level != prev_step_q) ?
		(item.dir_level ? sdsa_pkg::STEP_UP : sdsa_pkg::STEP_DOWN) : sdsa_pkg::STEP_HOLD;

	sdsa_sat_step #(.W(W)) u_pos_step (
		.value  (position_q),
		.step   (pos_step),
		.result (pos_next)
	);

	sdsa_sat_step #(.W(W)) u_tgt_step (
		.value  (target_q),
		.step   (tgt_step),
		.result (tgt_next)
	);

	// One extra bit keeps the error exact across the full signed range.
	assign diff = {tgt_next[W-1], tgt_next} - {pos_next[W-1], pos_next};
	assign mag  = diff[W] ? (W+1)'(-diff) : diff;

	// The latch holds only while the error stays below the deadband.
	assign held = reached_q && (CW'(mag) < CW'(deadband));
	assign reached_next = held || (diff == '0);

	always_comb begin
		result.drive_forward = !held && !diff[W] && (diff != '0);
		result.drive_reverse = !held && diff[W];
		result.at_target     = reached_next;
		result.position_now  = sdsa_pkg::FIELD_W'(pos_next);
		result.target_now    = sdsa_pkg::FIELD_W'(tgt_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_enc_q  <= '0;
			prev_step_q <= 1'b0;
			position_q  <= '0;
			target_q    <= '0;
			reached_q   <= 1'b0;
		end else if (advance) begin
			prev_enc_q  <= now_enc;
			prev_step_q <= item.step_level;
			position_q  <= pos_next;
			target_q    <= tgt_next;
			reached_q   <= reached_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/step_dir_dc_servo_axis.sv
// Step/direction DC servo axis with quadrature encoder feedback.
// An accepted beat waits in the input register, then moves into the result register when that is free.
// Throughput: one beat per cycle while the result side is ready, set by the axis state update.
// While a finished result waits downstream, the input register takes one more beat.
// Reset clears position, target, edge history and the reached latch, and
// loads the deadband register with 30.
`default_nettype none

module step_dir_dc_servo_axis #(
	parameter int POS_WIDTH = sdsa_pkg::POS_WIDTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdsa_chan_if.sink   cmd,
	sdsa_chan_if.source res,
	sdsa_chan_if.sink   cfg
);

	sdsa_pkg::in_item_t  item_s1;
	logic                valid_s1;
	sdsa_pkg::res_item_t res_q;
	logic                res_valid_q;
	sdsa_pkg::deadband_t deadband_q;
	sdsa_pkg::res_item_t core_res;
	logic                advance;

	// The held item moves into the result register when that register is free.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= sdsa_pkg::DEADBAND_RESET;
		end else if (cfg.valid) begin
			deadband_q <= sdsa_pkg::DEADBAND_W'(cfg.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) item_s1 <= cmd.data;
	end

	sdsa_axis_core #(.POS_WIDTH(POS_WIDTH)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.deadband (deadband_q),
		.result   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= core_res;
	end

endmodule

`default_nettype wire
